[src/pse_pkg.sv]
package pse_pkg;

    // Number format of the stack entries: signed fixed point, Q16.16.
    localparam int VALUE_W   = 32;
    localparam int FRAC_BITS = 16;

    // Default stack size and the width of the reported depth field.
    localparam int STACK_DEPTH_DEF = 64;
    localparam int DEPTH_W         = 7;

    // Entries in the queue between the decoder and the executor.
    localparam int QUEUE_DEPTH = 2;

    // Command codes of an input word.
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_APPLY  = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    // Operator character codes.
    localparam logic [7:0] OP_ADD = 8'h2B;
    localparam logic [7:0] OP_SUB = 8'h2D;
    localparam logic [7:0] OP_MUL = 8'h2A;
    localparam logic [7:0] OP_DIV = 8'h2F;

    // Status codes of a result word.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd2;
    localparam logic [2:0] ST_BAD_OP    = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;

    // Saturation limits.
    localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Input word.
    typedef struct packed {
        logic [1:0]          cmd;
        logic signed [31:0]  push_value;
        logic [7:0]          op_char;
    } item_t;

    // Result word.
    typedef struct packed {
        logic [2:0]          status;
        logic signed [31:0]  top_value;
        logic [6:0]          stack_depth;
    } result_t;

    // Decoded kind of work for the executor.
    typedef enum logic [2:0] {
        K_PUSH,
        K_ADD,
        K_SUB,
        K_MUL,
        K_DIV,
        K_BADOP,
        K_FINISH,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [VALUE_W-1:0]  value;
    } work_t;

    // Head of the work queue as seen by the executor.
    typedef struct packed {
        logic   valid;
        work_t  work;
    } head_t;

    // Executor states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LEFT,
        BK_EXEC,
        BK_DIVW,
        BK_FIN
    } state_t;

    // Request to the serial divider.
    typedef struct packed {
        logic [VALUE_W-1:0] rem_init;
        logic [VALUE_W-1:0] num_lo;
        logic [VALUE_W-1:0] divisor;
    } div_req_t;

endpackage

[src/pse_ram.sv]
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                  wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/pse_div.sv]
module pse_div
    import pse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  div_req_t           req,
    output logic               done,
    output logic [VALUE_W-1:0] quotient
);

    localparam int CNT_W = $clog2(VALUE_W);

    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [VALUE_W-1:0] dvs_reg, dvs_next;

    logic [VALUE_W:0]   shifted;
    logic [VALUE_W:0]   trial;
    logic               fits;

    // One restoring step: bring in the next dividend bit and try to subtract.
    assign shifted = {rem_reg, acc_reg[VALUE_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = ~trial[VALUE_W];

    // Sequencing: load on go, then one quotient bit per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        dvs_next  = dvs_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.rem_init;
            acc_next  = req.num_lo;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[VALUE_W-1:0] : shifted[VALUE_W-1:0];
            acc_next = {acc_reg[VALUE_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers; the quotient shifts in where the dividend shifts out.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

[src/pse_front.sv]
module pse_front
    import pse_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  item_t item,
    output logic  busy,
    input  logic  pop,
    output head_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             accept;
    work_t            cls_work;

    // Decode the command and operator into one kind of work.
    always_comb
    begin
        cls_work.value = item.push_value;
        unique case (item.cmd)
            CMD_PUSH:   cls_work.kind = K_PUSH;
            CMD_APPLY:
            begin
                unique case (item.op_char)
                    OP_ADD:  cls_work.kind = K_ADD;
                    OP_SUB:  cls_work.kind = K_SUB;
                    OP_MUL:  cls_work.kind = K_MUL;
                    OP_DIV:  cls_work.kind = K_DIV;
                    default: cls_work.kind = K_BADOP;
                endcase
            end
            CMD_FINISH: cls_work.kind = K_FINISH;
            CMD_NOP:    cls_work.kind = K_NOP;
        endcase
    end

    assign busy   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign accept = start && !busy;

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (accept && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !accept)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[wr_ptr_reg] <= cls_work;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.work  = slot_reg[rd_ptr_reg];

endmodule

[src/pse_back.sv]
module pse_back
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  head_t   head,
    output logic    pop,
    output logic    done,
    output result_t result
);

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

    state_t                state_reg, state_next;
    logic [SP_W-1:0]       sp_reg, sp_next;
    logic [VALUE_W-1:0]    top_reg, top_next;
    logic [VALUE_W-1:0]    left_reg, left_next;
    kind_t                 kind_reg, kind_next;
    logic [2*VALUE_W-1:0]  mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic                  done_reg, done_next;
    result_t               result_reg, result_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VALUE_W-1:0]    ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [VALUE_W-1:0]    ram_rdata;

    logic                  div_go;
    div_req_t              div_req;
    logic                  div_done;
    logic [VALUE_W-1:0]    div_quot;

    logic [SP_W-1:0]       sp_m1, sp_m2, sp_m3;
    logic [VALUE_W-1:0]    left_mag, right_mag;
    logic [VALUE_W:0]      sum_ext;
    logic [VALUE_W-1:0]    arith_res;
    logic [2*VALUE_W-1:0]  num_ext;
    logic                  div_ovf;
    logic [2*VALUE_W-1:0]  prod;
    logic [2*VALUE_W-1:0]  fin_mag;
    logic [VALUE_W-1:0]    fin_res;

    // Clamp a magnitude with a sign to the signed value range.
    function automatic logic [VALUE_W-1:0] saturate(input logic [2*VALUE_W-1:0] mag,
                                                     input logic neg);
        logic [2*VALUE_W-1:0] lim;
        logic [VALUE_W-1:0]   r;
        lim = {{VALUE_W{1'b0}}, VAL_MIN};
        if (neg)
        begin
            r = (mag > lim) ? VAL_MIN : -mag[VALUE_W-1:0];
        end
        else
        begin
            r = (mag >= lim) ? VAL_MAX : mag[VALUE_W-1:0];
        end
        return r;
    endfunction

    // Build a result word; the depth field keeps the low bits of the count.
    function automatic result_t make_result(input logic [2:0] status,
                                            input logic [VALUE_W-1:0] top,
                                            input logic [SP_W-1:0] sp);
        logic [SP_W+DEPTH_W-1:0] ext;
        result_t                 r;
        ext           = {{DEPTH_W{1'b0}}, sp};
        r.status      = status;
        r.top_value   = top;
        r.stack_depth = ext[DEPTH_W-1:0];
        return r;
    endfunction

    pse_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign sp_m1 = sp_reg - SP_W'(1);
    assign sp_m2 = sp_reg - SP_W'(2);
    assign sp_m3 = sp_reg - SP_W'(3);

    // Operand magnitudes; the right operand is the cached top of stack.
    assign left_mag  = left_reg[VALUE_W-1] ? -left_reg : left_reg;
    assign right_mag = top_reg[VALUE_W-1] ? -top_reg : top_reg;

    // Add and subtract with one guard bit, then saturate.
    assign sum_ext = (kind_reg == K_SUB)
                   ? {left_reg[VALUE_W-1], left_reg} - {top_reg[VALUE_W-1], top_reg}
                   : {left_reg[VALUE_W-1], left_reg} + {top_reg[VALUE_W-1], top_reg};
    assign arith_res = (sum_ext[VALUE_W] != sum_ext[VALUE_W-1])
                     ? (sum_ext[VALUE_W] ? VAL_MIN : VAL_MAX)
                     : sum_ext[VALUE_W-1:0];

    // Divide setup: the scaled dividend; a high half not below the divisor
    // means the quotient does not fit and saturates.
    assign num_ext = {{VALUE_W{1'b0}}, left_mag} << FRAC_BITS;
    assign div_ovf = (num_ext[2*VALUE_W-1:VALUE_W] >= right_mag);
    assign div_req.rem_init = num_ext[2*VALUE_W-1:VALUE_W];
    assign div_req.num_lo   = num_ext[VALUE_W-1:0];
    assign div_req.divisor  = right_mag;

    assign prod = (2*VALUE_W)'(left_mag) * (2*VALUE_W)'(right_mag);

    // Final scaling of a product, then sign and saturation.
    assign fin_mag = (kind_reg == K_MUL) ? (mag_reg >> FRAC_BITS) : mag_reg;
    assign fin_res = saturate(fin_mag, neg_reg);

    // Executor: next state, stack update and result word.
    always_comb
    begin
        state_next  = state_reg;
        sp_next     = sp_reg;
        top_next    = top_reg;
        left_next   = left_reg;
        kind_next   = kind_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        pop         = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = sp_reg[AW-1:0];
        ram_wdata   = head.work.value;
        ram_raddr   = sp_m2[AW-1:0];
        div_go      = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop       = 1'b1;
                    kind_next = head.work.kind;
                    done_next = 1'b1;
                    unique case (head.work.kind) inside
                        K_PUSH:
                        begin
                            if (sp_reg == SP_FULL)
                            begin
                                result_next = make_result(ST_FULL, top_reg, sp_reg);
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                top_next    = head.work.value;
                                sp_next     = sp_reg + SP_W'(1);
                                result_next = make_result(ST_OK, head.work.value,
                                                          sp_reg + SP_W'(1));
                            end
                        end
                        K_FINISH:
                        begin
                            if (sp_reg == '0)
                            begin
                                result_next = make_result(ST_EMPTY, '0, '0);
                            end
                            else
                            begin
                                sp_next     = '0;
                                result_next = make_result(ST_OK, top_reg, '0);
                            end
                        end
                        K_NOP:
                        begin
                            result_next = make_result(ST_OK,
                                                      (sp_reg != '0) ? top_reg : '0,
                                                      sp_reg);
                        end
                        K_ADD, K_SUB, K_MUL, K_DIV, K_BADOP:
                        begin
                            if (sp_reg == '0 || sp_reg == SP_W'(1))
                            begin
                                // Too few operands: any popped right operand is lost.
                                sp_next     = '0;
                                result_next = make_result(ST_UNDERFLOW, '0, '0);
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = BK_LEFT;
                            end
                        end
                    endcase
                end
            end

            BK_LEFT:
            begin
                // Left operand arrives; fetch the entry below it for the error paths.
                left_next  = ram_rdata;
                ram_raddr  = sp_m3[AW-1:0];
                state_next = BK_EXEC;
            end

            BK_EXEC:
            begin
                unique case (kind_reg) inside
                    K_ADD, K_SUB:
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = sp_m2[AW-1:0];
                        ram_wdata   = arith_res;
                        top_next    = arith_res;
                        sp_next     = sp_m1;
                        done_next   = 1'b1;
                        result_next = make_result(ST_OK, arith_res, sp_m1);
                        state_next  = BK_IDLE;
                    end
                    K_MUL:
                    begin
                        mag_next   = prod;
                        neg_next   = left_reg[VALUE_W-1] ^ top_reg[VALUE_W-1];
                        state_next = BK_FIN;
                    end
                    K_DIV:
                    begin
                        neg_next = left_reg[VALUE_W-1] ^ top_reg[VALUE_W-1];
                        if (top_reg == '0)
                        begin
                            // Divide by zero: both operands are dropped.
                            sp_next     = sp_m2;
                            top_next    = ram_rdata;
                            done_next   = 1'b1;
                            result_next = make_result(ST_DIV_ZERO,
                                                      (sp_m2 != '0) ? ram_rdata : '0, sp_m2);
                            state_next  = BK_IDLE;
                        end
                        else if (div_ovf)
                        begin
                            mag_next   = '1;
                            state_next = BK_FIN;
                        end
                        else
                        begin
                            div_go     = 1'b1;
                            state_next = BK_DIVW;
                        end
                    end
                    default:
                    begin
                        // Unknown operator: both operands are dropped.
                        sp_next     = sp_m2;
                        top_next    = ram_rdata;
                        done_next   = 1'b1;
                        result_next = make_result(ST_BAD_OP,
                                                  (sp_m2 != '0) ? ram_rdata : '0, sp_m2);
                        state_next  = BK_IDLE;
                    end
                endcase
            end

            BK_DIVW:
            begin
                if (div_done)
                begin
                    mag_next   = {{VALUE_W{1'b0}}, div_quot};
                    state_next = BK_FIN;
                end
            end

            BK_FIN:
            begin
                ram_we      = 1'b1;
                ram_waddr   = sp_m2[AW-1:0];
                ram_wdata   = fin_res;
                top_next    = fin_res;
                sp_next     = sp_m1;
                done_next   = 1'b1;
                result_next = make_result(ST_OK, fin_res, sp_m1);
                state_next  = BK_IDLE;
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            sp_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        left_reg   <= left_next;
        kind_reg   <= kind_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[src/postfix_stack_evaluator_top.sv]
// Postfix expression evaluator on a bounded stack of signed Q16.16 values.
// Input channel: a word (cmd, push_value, op_char) is taken at a rising edge
// where start is high and busy is low. cmd pushes a value, applies an
// operator (+ - * /) to the two top entries, finishes (reports and clears the
// stack) or does nothing.
// Output channel: every input word yields exactly one result word (status,
// top_value, stack_depth), shown for one cycle while done is high. The
// receiver cannot stall; results leave in input order.
// A two-word queue separates the decoder from the executor, so busy rises
// only when that queue is full.
// Path through the executor: push, finish, no-op and errors found before any
// operand read complete in its idle state; add, subtract, unknown operators and
// divide by zero end in its execute state, multiply and other divides in a final
// state after it, where a divide may first wait for the bit-serial divider, one
// quotient bit per cycle. The other operators are bounded by the stack memory's
// registered read port, used twice per operator. The executor takes a new word
// only in its idle state, so pushes run at one word per cycle back to back.
// Reset empties the stack and the queue; stack memory is not cleared.
module postfix_stack_evaluator_top
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    logic  pop;
    head_t head;

    pse_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .pop   (pop),
        .head  (head)
    );

    pse_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

[src/pse_checker.sv]
module pse_checker
    import pse_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    done,
    input result_t result
);

    // No result word may appear in the cycle after reset was seen.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !done)
        else $error("result word right after reset");

    // Finish on an empty stack reports zero value and zero depth.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_EMPTY |-> result.top_value == 0 && result.stack_depth == 0)
        else $error("empty finish with nonzero value or depth");

    // Underflow always leaves the stack empty.
    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_UNDERFLOW
            |-> result.top_value == 0 && result.stack_depth == 0)
        else $error("underflow left entries on the stack");

    // An empty stack reports a zero top value, except after a finish.
    a_zero_top: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.stack_depth == 0 && result.status != ST_OK |-> result.top_value == 0)
        else $error("nonzero top reported for an empty stack");

endmodule

bind postfix_stack_evaluator_top pse_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .done   (done),
    .result (result)
);
